// ===== rtl/ini_stream_tokenizer_parser_defines.svh =====
// ----------------------------------------------------------------------------
// INI parser assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef INI_STREAM_TOKENIZER_PARSER_DEFINES_SVH
`define INI_STREAM_TOKENIZER_PARSER_DEFINES_SVH

// implication checked every cycle outside reset
`define ISP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ISP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/isp_pkg.sv =====
// ----------------------------------------------------------------------------
// INI parser package
// Shared types, character codes and record codes.
// ----------------------------------------------------------------------------
package isp_pkg;

    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PR_LO  = 8'd32;
    localparam logic [7:0] CH_PR_HI  = 8'd126;

    localparam logic [1:0] KIND_ENTRY   = 2'd0;
    localparam logic [1:0] KIND_SECTION = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [2:0] ERR_NO_EQ     = 3'd0;
    localparam logic [2:0] ERR_NO_VALUE  = 3'd1;
    localparam logic [2:0] ERR_RB_OPENS  = 3'd2;
    localparam logic [2:0] ERR_NO_SECNM  = 3'd3;
    localparam logic [2:0] ERR_NO_CLOSE  = 3'd4;
    localparam logic [2:0] ERR_LB_CLOSES = 3'd5;
    localparam logic [2:0] ERR_UNEXP     = 3'd6;

    // byte classes from the front end; space is kept apart from tab and CR
    // because it continues a token
    typedef enum logic [3:0] {
        C_SKIP  = 4'd0,
        C_LF    = 4'd1,
        C_SEMI  = 4'd2,
        C_LBRK  = 4'd3,
        C_RBRK  = 4'd4,
        C_EQ    = 4'd5,
        C_PRINT = 4'd6,
        C_OTHER = 4'd7,
        C_SP    = 4'd8
    } t_cls;

    // classified request from front to back
    typedef struct packed {
        logic       byte_valid;
        t_cls       cls;
        logic       eod;
    } t_tok;

    localparam int TOK_BITS = $bits(t_tok);

    // record fields (32-bit view)
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] section;
        logic [31:0] nf;
        logic [31:0] nl;
        logic [31:0] vf;
        logic [31:0] vl;
        logic [31:0] line;
        logic [2:0]  err;
        logic        last;
        logic        done;
    } t_rec;

    function automatic t_cls classify(input logic [7:0] ch);
        t_cls c;
        if (ch == CH_SP) c = C_SP;
        else if (ch == CH_TAB || ch == CH_CR) c = C_SKIP;
        else if (ch == CH_LF)   c = C_LF;
        else if (ch == CH_SEMI) c = C_SEMI;
        else if (ch == CH_LBRK) c = C_LBRK;
        else if (ch == CH_RBRK) c = C_RBRK;
        else if (ch == CH_EQ)   c = C_EQ;
        else if (ch >= CH_PR_LO && ch <= CH_PR_HI) c = C_PRINT;
        else c = C_OTHER;
        return c;
    endfunction

endpackage

// ===== rtl/ini_stream_tokenizer_parser.sv =====
// Flow: a request accepted into the token queue is handled by the back end
// once it heads that queue and the result queue has room for two records;
// its records are registered into the result queue, whose head drives the ports.
// Throughput: one byte per cycle while not full; the back end takes one
// classified request per cycle while the result queue can take two records.
// Reset: synchronous, active low; clears queues and returns the parser to
// the start of a file.
// ----------------------------------------------------------------------------
// INI stream tokenizer and parser
// Front end classifies bytes into a short queue; back end runs the grammar.
// ----------------------------------------------------------------------------
module ini_stream_tokenizer_parser
    import isp_pkg::*;
#(
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_byte_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_data,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_record_kind,
    output logic [31:0] o_section_number,
    output logic [31:0] o_name_first,
    output logic [31:0] o_name_final,
    output logic [31:0] o_value_first,
    output logic [31:0] o_value_final,
    output logic [31:0] o_line_no,
    output logic [2:0]  o_error_code,
    output logic        o_last_of_run,
    output logic        o_file_done
);
    t_tok w_in, w_q;
    logic w_qempty, w_take, w_room2, w_wr0, w_wr1;
    t_rec w_rec0, w_rec1, w_out;

    // front end: classify; idle items are dropped
    always_comb begin
        w_in.byte_valid = i_byte_valid;
        w_in.cls        = classify(i_data_byte);
        w_in.eod        = i_end_of_data;
    end

    isp_fifo #(.WIDTH(TOK_BITS), .DEPTH(4)) u_tq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push && (i_byte_valid || i_end_of_data)), .i_data(w_in), .o_full(full),
        .i_pop(w_take), .o_empty(w_qempty), .o_data(w_q)
    );

    isp_back #(.POSITION_BITS(POSITION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_tok(w_q), .i_tok_vld(!w_qempty), .o_tok_take(w_take),
        .i_room2(w_room2), .o_wr0(w_wr0), .o_wr1(w_wr1),
        .o_rec0(w_rec0), .o_rec1(w_rec1)
    );

    isp_outq u_oq (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr0(w_wr0), .i_wr1(w_wr1), .i_rec0(w_rec0), .i_rec1(w_rec1),
        .o_room2(w_room2), .i_pop(pop), .o_empty(empty), .o_rec(w_out)
    );

    assign o_record_kind    = w_out.kind;
    assign o_section_number = w_out.section;
    assign o_name_first     = w_out.nf;
    assign o_name_final     = w_out.nl;
    assign o_value_first    = w_out.vf;
    assign o_value_final    = w_out.vl;
    assign o_line_no        = w_out.line;
    assign o_error_code     = w_out.err;
    assign o_last_of_run    = w_out.last;
    assign o_file_done      = w_out.done;
endmodule

// ===== rtl/isp_fifo.sv =====
// ----------------------------------------------------------------------------
// INI parser queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module isp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end
endmodule

// ===== rtl/isp_back.sv =====
// ----------------------------------------------------------------------------
// INI parser back end
// Lexer and grammar state; turns one classified request into up to two
// records, written into the result queue.
// ----------------------------------------------------------------------------
module isp_back
    import isp_pkg::*;
#(
    parameter int POSITION_BITS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_tok  i_tok,
    input  logic  i_tok_vld,
    output logic  o_tok_take,
    input  logic  i_room2,
    output logic  o_wr0,
    output logic  o_wr1,
    output t_rec  o_rec0,
    output t_rec  o_rec1
);
    localparam int PB = POSITION_BITS;

    typedef enum logic [2:0] {
        LX_BLANK   = 3'b001,
        LX_COMMENT = 3'b010,
        LX_TOKEN   = 3'b100
    } t_lex;

    typedef enum logic [5:0] {
        PH_START   = 6'b000001,
        PH_WANT_EQ = 6'b000010,
        PH_WANT_VL = 6'b000100,
        PH_WANT_SN = 6'b001000,
        PH_WANT_CL = 6'b010000,
        PH_FAILED  = 6'b100000
    } t_ph;

    t_lex          r_lex, n_lex;
    t_ph           r_ph, n_ph;
    logic [PB-1:0] r_off, n_off;
    logic [31:0]   r_line, n_line;
    logic [PB-1:0] r_tf, n_tf;
    logic [PB-1:0] r_hnf, n_hnf;
    logic [PB-1:0] r_hnl, n_hnl;
    logic [PB-1:0] r_ob, n_ob;
    logic [31:0]   r_sec, n_sec;

    logic          w_go;
    t_rec          w_r[2];
    logic [1:0]    w_cnt;

    assign w_go       = i_tok_vld && i_room2;
    assign o_tok_take = w_go;

    function automatic logic [2:0] miss(input t_ph p);
        logic [2:0] e;
        case (p)
            PH_WANT_EQ: e = ERR_NO_EQ;
            PH_WANT_VL: e = ERR_NO_VALUE;
            PH_WANT_SN: e = ERR_NO_SECNM;
            PH_WANT_CL: e = ERR_NO_CLOSE;
            default:    e = ERR_UNEXP;
        endcase
        return e;
    endfunction

    // next-state and record build, following byte then end of file
    always_comb begin
        logic [PB-1:0] off;
        logic          cont;
        logic          blank;
        t_cls          c;
        n_lex = r_lex; n_ph = r_ph; n_off = r_off; n_line = r_line;
        n_tf = r_tf; n_hnf = r_hnf; n_hnl = r_hnl; n_ob = r_ob; n_sec = r_sec;
        w_r[0] = '0; w_r[1] = '0; w_cnt = 2'd0;
        off   = r_off;
        c     = i_tok.cls;
        blank = 1'b0;
        cont  = 1'b0;
        if (i_tok.byte_valid) begin
            if (n_ph != PH_FAILED) begin
                if (n_lex == LX_TOKEN) begin
                    // spaces and ';' inside a token are kept; tab and CR end it
                    cont = (c == C_PRINT) || (c == C_SEMI) || (c == C_SP);
                    if (!cont) begin
                        n_lex = LX_BLANK;
                        if (n_ph == PH_WANT_EQ || n_ph == PH_WANT_CL) n_hnl = off - 1'b1;
                        else if (n_ph == PH_START) begin
                            w_r[w_cnt[0]] = '{KIND_ENTRY, n_sec, 32'(n_hnf), 32'(n_hnl),
                                              32'(n_tf), 32'(off - 1'b1), n_line,
                                              3'd0, 1'b0, 1'b0};
                            w_cnt = w_cnt + 1'b1;
                        end
                        blank = 1'b1;
                    end
                end else if (n_lex == LX_COMMENT) begin
                    if (c == C_LF) begin
                        n_line = n_line + 1'b1;
                        n_lex  = LX_BLANK;
                    end
                end else begin
                    blank = 1'b1;
                end
            end
            if (blank) begin
                case (c)
                    C_SKIP: ;
                    C_SP:   ;
                    C_LF:   n_line = n_line + 1'b1;
                    C_SEMI: n_lex = LX_COMMENT;
                    C_LBRK: begin
                        if (n_ph == PH_START) begin
                            n_ob = off; n_ph = PH_WANT_SN;
                        end else begin
                            w_r[w_cnt[0]] = '{KIND_ERROR, n_sec, 32'd0, 32'd0, 32'd0,
                                32'd0, n_line,
                                (n_ph == PH_WANT_CL) ? ERR_LB_CLOSES : miss(n_ph),
                                1'b0, 1'b1};
                            w_cnt = w_cnt + 1'b1; n_ph = PH_FAILED; n_lex = LX_BLANK;
                        end
                    end
                    C_RBRK: begin
                        if (n_ph == PH_WANT_CL) begin
                            n_sec = n_sec + 1'b1;
                            w_r[w_cnt[0]] = '{KIND_SECTION, n_sec, 32'(n_hnf), 32'(n_hnl),
                                              32'(n_ob), 32'(off), n_line, 3'd0,
                                              1'b0, 1'b0};
                            w_cnt = w_cnt + 1'b1; n_ph = PH_START;
                        end else begin
                            w_r[w_cnt[0]] = '{KIND_ERROR, n_sec, 32'd0, 32'd0, 32'd0,
                                32'd0, n_line,
                                (n_ph == PH_START) ? ERR_RB_OPENS : miss(n_ph),
                                1'b0, 1'b1};
                            w_cnt = w_cnt + 1'b1; n_ph = PH_FAILED; n_lex = LX_BLANK;
                        end
                    end
                    C_EQ: begin
                        if (n_ph == PH_WANT_EQ) n_ph = PH_WANT_VL;
                        else begin
                            w_r[w_cnt[0]] = '{KIND_ERROR, n_sec, 32'd0, 32'd0, 32'd0,
                                32'd0, n_line, miss(n_ph), 1'b0, 1'b1};
                            w_cnt = w_cnt + 1'b1; n_ph = PH_FAILED; n_lex = LX_BLANK;
                        end
                    end
                    C_PRINT: begin
                        if (n_ph == PH_START) begin
                            n_hnf = off; n_ph = PH_WANT_EQ; n_lex = LX_TOKEN;
                        end else if (n_ph == PH_WANT_VL) begin
                            n_tf = off; n_ph = PH_START; n_lex = LX_TOKEN;
                        end else if (n_ph == PH_WANT_SN) begin
                            n_hnf = off; n_ph = PH_WANT_CL; n_lex = LX_TOKEN;
                        end else begin
                            w_r[w_cnt[0]] = '{KIND_ERROR, n_sec, 32'd0, 32'd0, 32'd0,
                                32'd0, n_line, miss(n_ph), 1'b0, 1'b1};
                            w_cnt = w_cnt + 1'b1; n_ph = PH_FAILED; n_lex = LX_BLANK;
                        end
                    end
                    default: begin
                        w_r[w_cnt[0]] = '{KIND_ERROR, n_sec, 32'd0, 32'd0, 32'd0,
                            32'd0, n_line, miss(n_ph), 1'b0, 1'b1};
                        w_cnt = w_cnt + 1'b1; n_ph = PH_FAILED; n_lex = LX_BLANK;
                    end
                endcase
            end
            n_off = off + 1'b1;
        end
        if (i_tok.eod) begin
            if (n_ph != PH_FAILED) begin
                if (n_lex == LX_TOKEN) begin
                    if (n_ph == PH_WANT_EQ || n_ph == PH_WANT_CL) n_hnl = n_off - 1'b1;
                    else if (n_ph == PH_START) begin
                        w_r[w_cnt[0]] = '{KIND_ENTRY, n_sec, 32'(n_hnf), 32'(n_hnl),
                                          32'(n_tf), 32'(n_off - 1'b1), n_line,
                                          3'd0, 1'b0, 1'b0};
                        w_cnt = w_cnt + 1'b1;
                    end
                end
                if (n_ph == PH_START)
                    w_r[w_cnt[0]] = '{KIND_END, n_sec, 32'd0, 32'd0, 32'd0, 32'd0,
                                      n_line, 3'd0, 1'b0, 1'b1};
                else
                    w_r[w_cnt[0]] = '{KIND_ERROR, n_sec, 32'd0, 32'd0, 32'd0, 32'd0,
                                      n_line, miss(n_ph), 1'b0, 1'b1};
                w_cnt = w_cnt + 1'b1;
            end
            n_lex = LX_BLANK; n_ph = PH_START; n_off = '0; n_line = 32'd1;
            n_tf = '0; n_hnf = '0; n_hnl = '0; n_ob = '0; n_sec = '0;
        end
        if (w_cnt == 2'd1) w_r[0].last = 1'b1;
        if (w_cnt == 2'd2) w_r[1].last = 1'b1;
    end

    assign o_wr0  = w_go && (w_cnt != 2'd0);
    assign o_wr1  = w_go && (w_cnt == 2'd2);
    assign o_rec0 = w_r[0];
    assign o_rec1 = w_r[1];

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex <= LX_BLANK; r_ph <= PH_START; r_off <= '0; r_line <= 32'd1;
            r_tf <= '0; r_hnf <= '0; r_hnl <= '0; r_ob <= '0; r_sec <= '0;
        end else if (w_go) begin
            r_lex <= n_lex; r_ph <= n_ph; r_off <= n_off; r_line <= n_line;
            r_tf <= n_tf; r_hnf <= n_hnf; r_hnl <= n_hnl; r_ob <= n_ob; r_sec <= n_sec;
        end
    end
endmodule

// ===== rtl/isp_outq.sv =====
// ----------------------------------------------------------------------------
// INI parser result queue
// Takes up to two records a cycle, hands out one; reports room for two.
// ----------------------------------------------------------------------------
module isp_outq
    import isp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr0,
    input  logic i_wr1,
    input  t_rec i_rec0,
    input  t_rec i_rec1,
    output logic o_room2,
    input  logic i_pop,
    output logic o_empty,
    output t_rec o_rec
);
    localparam int DEPTH = 4;

    t_rec       r_mem [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    assign o_empty = (r_cnt == 3'd0);
    assign o_room2 = (r_cnt <= 3'(DEPTH - 2));
    assign o_rec   = r_mem[r_rp];
    assign w_pop   = i_pop && !o_empty;

    // pointers and count; writers only write when room for two
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + 2'(i_wr0) + 2'(i_wr1);
            r_rp  <= r_rp + 2'(w_pop);
            r_cnt <= r_cnt + 3'(i_wr0) + 3'(i_wr1) - 3'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr0) r_mem[r_wp] <= i_rec0;
        if (i_wr1) r_mem[r_wp + 2'd1] <= i_rec1;
    end
endmodule

// ===== rtl/isp_checker.sv =====
// ----------------------------------------------------------------------------
// INI parser port checker
// Port-level properties of the result stream.
// ----------------------------------------------------------------------------
`include "ini_stream_tokenizer_parser_defines.svh"

module isp_checker
    import isp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_record_kind,
    input logic [2:0]  o_error_code,
    input logic        o_file_done,
    input logic [31:0] o_line_no
);
    logic w_fin_kind;
    logic w_err_kind;

    assign w_fin_kind = (o_record_kind == KIND_END) || (o_record_kind == KIND_ERROR);
    assign w_err_kind = (o_record_kind == KIND_ERROR);

    // finishing records are exactly the end and error kinds
    `ISP_ASSERT_IMP(a_done_kind, i_clk, i_rst_n, !empty, o_file_done == w_fin_kind, "file_done")
    // error code only on error records
    `ISP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, !empty && !w_err_kind, o_error_code == 3'd0, "err")
    // line count starts at one
    `ISP_ASSERT_IMP(a_line_pos, i_clk, i_rst_n, !empty, o_line_no != 32'd0, "line count zero")
    // stalled result holds
    `ISP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_record_kind), "drop")
endmodule

bind ini_stream_tokenizer_parser isp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop),
    .o_record_kind(o_record_kind), .o_error_code(o_error_code),
    .o_file_done(o_file_done), .o_line_no(o_line_no)
);

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// INI parser testbench
// Sends INI byte streams through the push/full queue, predicts entry, header,
// end and error records in a local parser, and compares each popped record.
// ----------------------------------------------------------------------------
module tb
    import isp_pkg::*;
();

    typedef enum logic [1:0] {
        LX_BLANK   = 2'd0,
        LX_COMMENT = 2'd1,
        LX_TOKEN   = 2'd2
    } t_lex;

    typedef enum logic [2:0] {
        GP_START   = 3'd0,
        GP_WANT_EQ = 3'd1,
        GP_WANT_VAL = 3'd2,
        GP_WANT_SEC = 3'd3,
        GP_WANT_CLS = 3'd4,
        GP_FAILED  = 3'd5
    } t_phase;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_byte_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_data = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_record_kind;
    logic [31:0] o_section_number;
    logic [31:0] o_name_first;
    logic [31:0] o_name_final;
    logic [31:0] o_value_first;
    logic [31:0] o_value_final;
    logic [31:0] o_line_no;
    logic [2:0]  o_error_code;
    logic        o_last_of_run;
    logic        o_file_done;

    ini_stream_tokenizer_parser u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_byte_valid     (i_byte_valid),
        .i_data_byte      (i_data_byte),
        .i_end_of_data    (i_end_of_data),
        .empty            (empty),
        .pop              (pop),
        .o_record_kind    (o_record_kind),
        .o_section_number (o_section_number),
        .o_name_first     (o_name_first),
        .o_name_final     (o_name_final),
        .o_value_first    (o_value_first),
        .o_value_final    (o_value_final),
        .o_line_no        (o_line_no),
        .o_error_code     (o_error_code),
        .o_last_of_run    (o_last_of_run),
        .o_file_done      (o_file_done)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    t_lex        lex_mode;
    t_phase      phase;
    logic [31:0] pos;
    logic [31:0] line_cnt;
    logic [31:0] tok_first;
    logic [31:0] nm_first;
    logic [31:0] nm_final;
    logic [31:0] lbrk_pos;
    logic [31:0] sect_cnt;

    t_rec        pending_records[$];
    t_rec        run_recs[$];
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    bit          rx_hold = 1'b0;
    bit          rx_noidle = 1'b0;
    bit          tx_noidle = 1'b0;

    function automatic void parser_clear();
        lex_mode = LX_BLANK;
        phase    = GP_START;
        pos      = 32'd0;
        line_cnt = 32'd1;
        tok_first = 32'd0;
        nm_first = 32'd0;
        nm_final = 32'd0;
        lbrk_pos = 32'd0;
        sect_cnt = 32'd0;
    endfunction

    function automatic void add_record(logic [1:0] kind, logic [31:0] nf, logic [31:0] nl,
                                       logic [31:0] vf, logic [31:0] vl, logic [2:0] err,
                                       logic done);
        t_rec r;
        r.kind = kind; r.section = sect_cnt; r.nf = nf; r.nl = nl; r.vf = vf; r.vl = vl;
        r.line = line_cnt; r.err = err; r.last = 1'b0; r.done = done;
        run_recs.push_back(r);
    endfunction

    function automatic void raise_error(logic [2:0] code);
        add_record(KIND_ERROR, 0, 0, 0, 0, code, 1'b1);
        phase = GP_FAILED;
        lex_mode = LX_BLANK;
    endfunction

    function automatic logic [2:0] miss_code();
        case (phase)
            GP_WANT_EQ:  return ERR_NO_EQ;
            GP_WANT_VAL: return ERR_NO_VALUE;
            GP_WANT_SEC: return ERR_NO_SECNM;
            GP_WANT_CLS: return ERR_NO_CLOSE;
            default:     return ERR_UNEXP;
        endcase
    endfunction

    function automatic void close_token(logic [31:0] last);
        lex_mode = LX_BLANK;
        if (phase == GP_WANT_EQ || phase == GP_WANT_CLS) nm_final = last;
        else if (phase == GP_START)
            add_record(KIND_ENTRY, nm_first, nm_final, tok_first, last, ERR_NO_EQ, 1'b0);
    endfunction

    function automatic void between_tokens(logic [7:0] ch, logic [31:0] off);
        if (ch == CH_SP || ch == CH_TAB || ch == CH_CR) return;
        if (ch == CH_LF) begin
            line_cnt++;
        end else if (ch == CH_SEMI) begin
            lex_mode = LX_COMMENT;
        end else if (ch == CH_LBRK) begin
            if (phase == GP_START) begin
                lbrk_pos = off;
                phase = GP_WANT_SEC;
            end else if (phase == GP_WANT_CLS) raise_error(ERR_LB_CLOSES);
            else raise_error(miss_code());
        end else if (ch == CH_RBRK) begin
            if (phase == GP_START) raise_error(ERR_RB_OPENS);
            else if (phase == GP_WANT_CLS) begin
                sect_cnt++;
                add_record(KIND_SECTION, nm_first, nm_final, lbrk_pos, off, ERR_NO_EQ, 1'b0);
                phase = GP_START;
            end else raise_error(miss_code());
        end else if (ch == CH_EQ) begin
            if (phase == GP_WANT_EQ) phase = GP_WANT_VAL;
            else raise_error(miss_code());
        end else if (ch >= CH_PR_LO && ch <= CH_PR_HI) begin
            case (phase)
                GP_START: begin
                    nm_first = off; phase = GP_WANT_EQ; lex_mode = LX_TOKEN;
                end
                GP_WANT_VAL: begin
                    tok_first = off; phase = GP_START; lex_mode = LX_TOKEN;
                end
                GP_WANT_SEC: begin
                    nm_first = off; phase = GP_WANT_CLS; lex_mode = LX_TOKEN;
                end
                default: raise_error(miss_code());
            endcase
        end else begin
            raise_error(miss_code());
        end
    endfunction

    // advance the parser by one request and queue the records it yields
    function automatic void parse_request(logic bv, logic [7:0] ch, logic eod);
        logic cont;
        run_recs.delete();
        if (bv) begin
            if (phase != GP_FAILED) begin
                if (lex_mode == LX_TOKEN) begin
                    cont = ch >= CH_PR_LO && ch <= CH_PR_HI && ch != CH_EQ &&
                           ch != CH_LBRK && ch != CH_RBRK;
                    if (!cont) begin
                        close_token(pos - 32'd1);
                        between_tokens(ch, pos);
                    end
                end else if (lex_mode == LX_COMMENT) begin
                    if (ch == CH_LF) begin
                        line_cnt++;
                        lex_mode = LX_BLANK;
                    end
                end else begin
                    between_tokens(ch, pos);
                end
            end
            pos++;
        end
        if (eod) begin
            if (phase != GP_FAILED) begin
                if (lex_mode == LX_TOKEN) close_token(pos - 32'd1);
                if (phase == GP_START) add_record(KIND_END, 0, 0, 0, 0, ERR_NO_EQ, 1'b1);
                else raise_error(miss_code());
            end
            parser_clear();
        end
        if (run_recs.size() > 0) run_recs[run_recs.size() - 1].last = 1'b1;
        foreach (run_recs[k]) pending_records.push_back(run_recs[k]);
    endfunction

    // short gaps mostly, long now and then
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive at the falling edge, hold until accepted at a rising edge
    task automatic send_request(logic bv, logic [7:0] ch, logic eod);
        int gap;
        gap = tx_noidle ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_byte_valid <= bv;
        i_data_byte <= ch;
        i_end_of_data <= eod;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        parse_request(bv, ch, eod);
    endtask

    task automatic send_text(string s, logic eod);
        for (int k = 0; k < s.len(); k++)
            send_request(1'b1, s[k], eod && (k == s.len() - 1));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_records.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // random byte biased toward INI syntax
    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return CH_LF;
            1: return CH_SP;
            2: return CH_EQ;
            3: return CH_LBRK;
            4: return CH_RBRK;
            5: return CH_SEMI;
            6: return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(33, 126));
        endcase
    endfunction

    function automatic string rand_word();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
            logic [7:0] c;
            c = 8'($urandom_range(33, 126));
            if (c == CH_EQ || c == CH_LBRK || c == CH_RBRK || c == CH_SEMI) c = "x";
            s = {s, string'(c)};
        end
        if ($urandom_range(0, 3) == 0) s = {s, " y"};
        return s;
    endfunction

    // one well-formed line: entry, header, comment or blank
    function automatic string rand_line();
        case ($urandom_range(0, 5))
            0: return {"[", rand_word(), "]\n"};
            1: return "; note\n";
            2: return "\r\n";
            default: return {rand_word(), " = ", rand_word(), "\n"};
        endcase
    endfunction

    task automatic test_directed();
        send_text("a=b\n[s]\nk = v v ;c\n", 1'b0);
        send_text("; tail", 1'b1);
        send_text("x=1", 1'b1);
        send_request(1'b0, 8'd0, 1'b0);
        send_request(1'b0, 8'd0, 1'b1);
        send_text("a b\n", 1'b1);
        send_text("a=\n", 1'b1);
        send_text("]", 1'b1);
        send_text("[]", 1'b1);
        send_text("[a", 1'b1);
        send_text("[a[", 1'b1);
        send_text("=", 1'b1);
        send_request(1'b1, 8'hFF, 1'b1);
        send_request(1'b1, 8'h00, 1'b1);
        send_request(1'b1, 8'h7F, 1'b1);
    endtask

    task automatic test_random_files();
        int sent;
        sent = 0;
        while (sent < 1900) begin
            string f;
            f = "";
            repeat ($urandom_range(1, 6)) f = {f, rand_line()};
            if ($urandom_range(0, 4) == 0) begin
                // corrupt one byte
                int p;
                p = $urandom_range(0, f.len() - 1);
                f.putc(p, noise_byte());
            end
            if ($urandom_range(0, 5) == 0) f = {f, rand_word()};
            send_text(f, 1'b1);
            sent += f.len();
            if ($urandom_range(0, 7) == 0) begin
                send_request(1'b0, 8'd0, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // receiver stalls while the sender keeps offering requests
    task automatic test_backpressure();
        rx_hold = 1'b1;
        for (int k = 0; k < 60; k++)
            send_request(1'b1, (noise_byte() == CH_LF) ? CH_LF : "a", 1'b1);
        wait_drained();
    endtask

    task automatic test_no_idle();
        rx_noidle = 1'b1;
        tx_noidle = 1'b1;
        for (int k = 0; k < 40; k++)
            send_request(1'b1, (k % 4 == 3) ? CH_LF : "q", (k % 8 == 7));
        tx_noidle = 1'b0;
        rx_noidle = 1'b0;
    endtask

    // receiver: random pop gaps, one long counted hold when asked
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (rx_hold) begin
                pop <= 1'b0;
                repeat (300) @(negedge i_clk);
                rx_hold = 1'b0;
            end
            gap = rx_noidle ? 0 : pick_gap();
            pop <= (gap == 0);
            if (gap > 0) begin
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_rec got;
        t_rec exp_rec;
        if (i_rst_n && pop && !empty) begin
            got = '{o_record_kind, o_section_number, o_name_first, o_name_final,
                    o_value_first, o_value_final, o_line_no, o_error_code,
                    o_last_of_run, o_file_done};
            if (pending_records.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10) $display("unexpected record %p", got);
            end else begin
                exp_rec = pending_records.pop_front();
                if (got !== exp_rec) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("record differs: expected %p actual %p", exp_rec, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("ini_stream_tokenizer_parser: mismatch");
            $finish;
        end
    end

    initial begin
        parser_clear();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random_files();
        wait_drained();
        test_no_idle();
        send_request(1'b0, 8'd0, 1'b1);
        wait_drained();
        if (mismatch_cnt == 0 && pending_records.size() == 0) begin
            $display("ini_stream_tokenizer_parser: match");
        end else begin
            $display("ini_stream_tokenizer_parser: mismatch");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/isp_pkg.sv
rtl/isp_fifo.sv
rtl/isp_back.sv
rtl/isp_outq.sv
rtl/ini_stream_tokenizer_parser.sv
rtl/isp_checker.sv
tb/sv/tb.sv
